### hdl/lrupr_pkg.sv
// Shared types and constants of the LRU page replacement unit.
package lrupr_pkg;

  // Sequencer states of the replacement engine
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lrupr_state_t;

  localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;
  localparam logic [3:0]  CFG_FRAMES = 4'd3;

endpackage

### hdl/lrupr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrupr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/lru_page_replacement_unit.sv
// Top level of the LRU page replacement unit (timestamp scheme).
//
// Input channel: page and last_access, transferred when in_valid is high
// and in_stall is low. Output channel: hit, frame_index, evicted_valid,
// evicted_page, fault_count and string_done, transferred when out_valid
// is high and out_stall is low. One result per input item.
// Configuration: cfg_we writes cfg_wdata into frames_in_use (0 acts as 1,
// values above MAX_FRAMES act as MAX_FRAMES); write only while idle.
// Each item runs in order through a scan that reads n frames, one frame a
// cycle, through the single read port of the page and stamp RAMs, n being
// the active frame count; the compare of the last frame; and an update
// that writes the RAMs and loads the output register. The next item can
// transfer only once that update is done, so items do not overlap.
// in_stall stays high while an item is in work. A finished result waits in
// the output register while out_stall is high; the next item is accepted
// meanwhile, but its update waits until the previous result is transferred.
// Reset empties all frames (valid bits clear at once), zeroes the access
// clock and fault total and sets frames_in_use to 3. A result marked
// string_done returns the same state, keeping frames_in_use.
module lru_page_replacement_unit
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] page,
  input  logic        last_access,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [2:0]  frame_index,
  output logic        evicted_valid,
  output logic [15:0] evicted_page,
  output logic [31:0] fault_count,
  output logic        string_done
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  lrupr_state_t state, state_next;

  logic [3:0]            frames_in_use;
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [31:0]           access_clock;
  logic [31:0]           faults_total;

  logic [15:0]      page_r;
  logic             done_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] n_cfg;
  logic [7:0]       n_wide;

  logic [CNT_W-1:0] iss_cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;

  logic             hit_r;
  logic [IDX_W-1:0] hit_idx;
  logic             found_empty;
  logic [IDX_W-1:0] vic_idx;
  logic [31:0]      best_stamp;
  logic [15:0]      vic_page;

  logic [15:0] pg_rd;
  logic [31:0] st_rd;

  logic             in_xfer;
  logic             out_free;
  logic             commit;
  logic [IDX_W-1:0] use_idx;
  logic [31:0]      faults_next;
  logic [7:0]       idx_wide;
  logic             cmp_valid_frame;
  logic             stamp_less;

  // Clamp the configured frame count to 1..MAX_FRAMES
  always_comb begin
    n_wide = {4'd0, frames_in_use};
    if (n_wide == 8'd0) begin
      n_wide = 8'd1;
    end
    if (n_wide > 8'(MAX_FRAMES)) begin
      n_wide = 8'(MAX_FRAMES);
    end
    n_cfg = CNT_W'(n_wide);
  end

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == ST_UPDATE) && out_free;
  assign use_idx  = hit_r ? hit_idx : vic_idx;

  // Saturating fault total including this reference
  always_comb begin
    faults_next = faults_total;
    if (!hit_r && (faults_total != SAT32)) begin
      faults_next = faults_total + 32'd1;
    end
  end

  // Page and stamp stores, one frame read per cycle
  lrupr_ram #(
    .WIDTH (16),
    .DEPTH (MAX_FRAMES)
  ) u_page_ram (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (use_idx),
    .wr_data (page_r),
    .rd_addr (iss_cnt[IDX_W-1:0]),
    .rd_data (pg_rd)
  );

  lrupr_ram #(
    .WIDTH (32),
    .DEPTH (MAX_FRAMES)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (use_idx),
    .wr_data (access_clock),
    .rd_addr (iss_cnt[IDX_W-1:0]),
    .rd_data (st_rd)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (iss_cnt == n_r) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_FRAMES;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // Latch the item and frame count at transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      page_r <= page;
      done_r <= last_access;
      n_r    <= n_cfg;
    end
  end

  // Issue one frame read a cycle; the compare follows in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_cnt <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= 1'b0;
      if (in_xfer) begin
        iss_cnt <= '0;
      end else if ((state == ST_SCAN) && (iss_cnt != n_r)) begin
        iss_cnt <= iss_cnt + CNT_W'(1);
        cmp_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= iss_cnt[IDX_W-1:0];
  end

  // Shared compare unit: page match and stamp order of the returned frame
  assign cmp_valid_frame = frame_valid[cmp_idx];
  assign stamp_less      = (st_rd < best_stamp);

  // Track first hit and the victim over the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_r       <= 1'b0;
      found_empty <= 1'b0;
    end else if (in_xfer) begin
      hit_r       <= 1'b0;
      found_empty <= 1'b0;
    end else if (cmp_vld) begin
      if (cmp_valid_frame && (pg_rd == page_r) && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (!cmp_valid_frame && !found_empty) begin
        found_empty <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld) begin
      if (cmp_valid_frame && (pg_rd == page_r) && !hit_r) begin
        hit_idx <= cmp_idx;
      end
      if (!cmp_valid_frame) begin
        if (!found_empty) begin
          vic_idx <= cmp_idx;
        end
      end else if (!found_empty && ((cmp_idx == '0) || stamp_less)) begin
        best_stamp <= st_rd;
        vic_idx    <= cmp_idx;
        vic_page   <= pg_rd;
      end
    end
  end

  // Commit frame state, clock and fault total; clear at end of string
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid  <= '0;
      access_clock <= '0;
      faults_total <= '0;
    end else if (commit) begin
      if (done_r) begin
        frame_valid  <= '0;
        access_clock <= '0;
        faults_total <= '0;
      end else begin
        frame_valid[use_idx] <= 1'b1;
        faults_total         <= faults_next;
        if (access_clock != SAT32) begin
          access_clock <= access_clock + 32'd1;
        end
      end
    end
  end

  // Output register: hold while stalled, load on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign idx_wide = 8'(use_idx);

  always_ff @(posedge clk) begin
    if (commit) begin
      hit           <= hit_r;
      frame_index   <= idx_wide[2:0];
      evicted_valid <= !hit_r && !found_empty;
      evicted_page  <= (!hit_r && !found_empty) ? vic_page : 16'd0;
      fault_count   <= faults_next;
      string_done   <= done_r;
    end
  end

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("hit result reports an evicted page");

  // Scan never issues past the active frame count
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (iss_cnt <= n_r))
    else $error("scan issued beyond active frames");

  // An accepted item starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_SCAN) && (iss_cnt == '0))
    else $error("accepted item did not start a scan");

  // A hit frame is a resident frame
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_UPDATE) && hit_r) |-> frame_valid[hit_idx])
    else $error("hit on an empty frame");

endmodule
